[rtl/bps_pkg.sv]
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the buzzer pattern sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 64;
	localparam logic [15:0] DEFAULT_FREQ_RST = 16'd1000;

	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_SINGLE   = 3'd1,
		CMD_REPEAT   = 3'd2,
		CMD_TEMPLATE = 3'd3,
		CMD_STOP     = 3'd4,
		CMD_LOAD     = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_NONE     = 2'd0,
		MODE_SINGLE   = 2'd1,
		MODE_REPEAT   = 2'd2,
		MODE_TEMPLATE = 2'd3
	} mode_t;

endpackage : bps_pkg

`default_nettype wire

[rtl/buzzer_pattern_sequencer.sv]
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer
// Beeper pattern controller: single, repeat and table-driven template modes.
// ----------------------------------------------------------------------------
// Every accepted transaction (a tick, a start, a stop or a table load) returns
// one result giving the buzzer output after it: tone_on, sound_freq (zero when
// silent) and busy_res. An accepted transaction is first held in the stage 1
// registers together with the data read from the time and frequency tables
// (synchronous memories); then the pattern state is updated and the output
// register loaded. The block accepts one transaction per cycle while the output
// channel is not stalled; the table read address of a new transaction is forwarded
// from the step index being computed for the one ahead of it. Table entries are
// undefined until loaded and need no clearing after reset, so the block is
// ready as soon as reset is released. default_freq may only be written while
// no transaction is in flight.
`default_nettype none

module buzzer_pattern_sequencer
	import bps_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [15:0] duration_ms,
	input  wire logic [15:0] pause_ms,
	input  wire logic [15:0] tone_freq,
	input  wire logic [7:0]  repeat_count,
	input  wire logic [6:0]  template_size,
	input  wire logic        use_freq_table,
	input  wire logic [5:0]  entry_index,
	input  wire logic [15:0] entry_time,
	input  wire logic [15:0] entry_freq,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             tone_on,
	output logic [15:0]      sound_freq,
	output logic             busy_res
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [7:0]  DEPTH8 = 8'(TABLE_DEPTH);

	// configuration register
	logic [15:0] default_freq_q;

	// pattern state
	mode_t       play_mode_q, play_mode_d;
	logic        running_q, running_d;
	logic        sounding_q, sounding_d;
	logic [15:0] base_freq_q, base_freq_d;
	logic [15:0] driven_freq_q, driven_freq_d;
	logic [15:0] on_time_q, on_time_d;
	logic [15:0] off_time_q, off_time_d;
	logic [7:0]  cycles_wanted_q, cycles_wanted_d;
	logic [7:0]  cycles_done_q, cycles_done_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic [7:0]  step_index_q, step_index_d;
	logic [7:0]  step_count_q, step_count_d;
	logic        table_freq_on_q, table_freq_on_d;

	// tables
	logic [15:0] time_mem [TABLE_DEPTH];
	logic [15:0] freq_mem [TABLE_DEPTH];

	// stage 1: transaction plus table read data
	logic        valid_s1;
	logic [2:0]  cmd_s1;
	logic [15:0] dur_s1;
	logic [15:0] pause_s1;
	logic [15:0] freq_s1;
	logic [7:0]  count_s1;
	logic [6:0]  size_s1;
	logic        use_tab_s1;
	logic [15:0] time_rd_s1;
	logic [15:0] freq_rd_s1;

	// output register
	logic        out_valid_q;
	logic        tone_on_q;
	logic [15:0] sound_freq_q;
	logic        busy_q;

	logic        accept;
	logic        adv_s1;
	logic [7:0]  step_fwd;
	logic [7:0]  step_fwd_inc;
	logic [7:0]  step_half;
	logic [7:0]  entry_idx8;
	logic        load_ok;
	logic [AW-1:0] time_addr;
	logic [AW-1:0] freq_addr;
	logic [15:0] chosen;
	logic [15:0] el_inc;
	logic [7:0]  cd_inc;
	logic [7:0]  si_inc;
	logic [7:0]  size_sat;

	// ------------------------------------------------------------------------
	// handshakes
	// ------------------------------------------------------------------------
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	// ------------------------------------------------------------------------
	// table access
	// ------------------------------------------------------------------------
	// forward the step index left by the transaction ahead
	assign step_fwd     = valid_s1 ? step_index_d : step_index_q;
	assign step_fwd_inc = step_fwd + 8'd1;
	assign step_half    = {1'b0, step_fwd_inc[7:1]};
	assign time_addr    = step_fwd[AW-1:0];
	assign freq_addr    = (command == CMD_TEMPLATE) ? '0 : step_half[AW-1:0];

	assign entry_idx8 = {2'b00, entry_index};
	assign load_ok    = accept && (command == CMD_LOAD) && (entry_idx8 < DEPTH8);

	always_ff @(posedge clk) begin
		if (load_ok) begin
			time_mem[entry_idx8[AW-1:0]] <= entry_time;
		end
		if (accept) begin
			time_rd_s1 <= time_mem[time_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			freq_mem[entry_idx8[AW-1:0]] <= entry_freq;
		end
		if (accept) begin
			freq_rd_s1 <= freq_mem[freq_addr];
		end
	end

	// ------------------------------------------------------------------------
	// stage 1 registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= command;
			dur_s1     <= duration_ms;
			pause_s1   <= pause_ms;
			freq_s1    <= tone_freq;
			count_s1   <= repeat_count;
			size_s1    <= template_size;
			use_tab_s1 <= use_freq_table;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_freq_q <= DEFAULT_FREQ_RST;
		end else if (cfg_wr_en) begin
			default_freq_q <= cfg_wr_data;
		end
	end

	// ------------------------------------------------------------------------
	// state update
	// ------------------------------------------------------------------------
	assign chosen   = (freq_s1 != 16'd0) ? freq_s1 : default_freq_q;
	assign el_inc   = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	assign cd_inc   = cycles_done_q + 8'd1;
	assign si_inc   = step_index_q + 8'd1;
	assign size_sat = ({1'b0, size_s1} > DEPTH8) ? DEPTH8 : {1'b0, size_s1};

	always_comb begin
		play_mode_d     = play_mode_q;
		running_d       = running_q;
		sounding_d      = sounding_q;
		base_freq_d     = base_freq_q;
		driven_freq_d   = driven_freq_q;
		on_time_d       = on_time_q;
		off_time_d      = off_time_q;
		cycles_wanted_d = cycles_wanted_q;
		cycles_done_d   = cycles_done_q;
		elapsed_d       = elapsed_q;
		step_index_d    = step_index_q;
		step_count_d    = step_count_q;
		table_freq_on_d = table_freq_on_q;

		case (cmd_s1)
			CMD_TICK: begin
				if (running_q) begin
					elapsed_d = el_inc;
					case (play_mode_q)
						MODE_SINGLE: begin
							if (el_inc >= on_time_q) begin
								sounding_d  = 1'b0;
								play_mode_d = MODE_NONE;
								running_d   = 1'b0;
							end
						end
						MODE_REPEAT: begin
							if (sounding_q && el_inc >= on_time_q) begin
								sounding_d = 1'b0;
								elapsed_d  = 16'd0;
							end else if (!sounding_q && el_inc >= off_time_q) begin
								cycles_done_d = cd_inc;
								if (cd_inc >= cycles_wanted_q) begin
									sounding_d  = 1'b0;
									play_mode_d = MODE_NONE;
									running_d   = 1'b0;
								end else begin
									driven_freq_d = base_freq_q;
									sounding_d    = 1'b1;
									elapsed_d     = 16'd0;
								end
							end
						end
						MODE_TEMPLATE: begin
							if (el_inc >= time_rd_s1) begin
								elapsed_d    = 16'd0;
								step_index_d = si_inc;
								if (si_inc >= step_count_q) begin
									sounding_d  = 1'b0;
									play_mode_d = MODE_NONE;
									running_d   = 1'b0;
								end else if (!si_inc[0]) begin
									driven_freq_d = table_freq_on_q ? freq_rd_s1 : base_freq_q;
									sounding_d    = 1'b1;
								end else begin
									sounding_d = 1'b0;
								end
							end
						end
						default: begin
							sounding_d  = 1'b0;
							play_mode_d = MODE_NONE;
							running_d   = 1'b0;
						end
					endcase
				end
			end
			CMD_SINGLE: begin
				play_mode_d   = MODE_SINGLE;
				base_freq_d   = chosen;
				on_time_d     = dur_s1;
				elapsed_d     = 16'd0;
				driven_freq_d = chosen;
				sounding_d    = 1'b1;
				running_d     = 1'b1;
			end
			CMD_REPEAT: begin
				if (count_s1 == 8'd0) begin
					sounding_d  = 1'b0;
					play_mode_d = MODE_NONE;
					running_d   = 1'b0;
				end else begin
					play_mode_d     = MODE_REPEAT;
					base_freq_d     = chosen;
					on_time_d       = dur_s1;
					off_time_d      = pause_s1;
					cycles_wanted_d = count_s1;
					cycles_done_d   = 8'd0;
					elapsed_d       = 16'd0;
					driven_freq_d   = chosen;
					sounding_d      = 1'b1;
					running_d       = 1'b1;
				end
			end
			CMD_TEMPLATE: begin
				if (size_sat == 8'd0) begin
					sounding_d  = 1'b0;
					play_mode_d = MODE_NONE;
					running_d   = 1'b0;
				end else begin
					play_mode_d     = MODE_TEMPLATE;
					base_freq_d     = chosen;
					table_freq_on_d = use_tab_s1;
					step_count_d    = size_sat;
					step_index_d    = 8'd0;
					elapsed_d       = 16'd0;
					driven_freq_d   = use_tab_s1 ? freq_rd_s1 : chosen;
					sounding_d      = 1'b1;
					running_d       = 1'b1;
				end
			end
			CMD_STOP: begin
				sounding_d  = 1'b0;
				play_mode_d = MODE_NONE;
				running_d   = 1'b0;
			end
			default: begin
				// table loads and unused codes leave the pattern alone
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_mode_q     <= MODE_NONE;
			running_q       <= 1'b0;
			sounding_q      <= 1'b0;
			base_freq_q     <= 16'd0;
			driven_freq_q   <= 16'd0;
			on_time_q       <= 16'd0;
			off_time_q      <= 16'd0;
			cycles_wanted_q <= 8'd0;
			cycles_done_q   <= 8'd0;
			elapsed_q       <= 16'd0;
			step_index_q    <= 8'd0;
			step_count_q    <= 8'd0;
			table_freq_on_q <= 1'b0;
		end else if (adv_s1) begin
			play_mode_q     <= play_mode_d;
			running_q       <= running_d;
			sounding_q      <= sounding_d;
			base_freq_q     <= base_freq_d;
			driven_freq_q   <= driven_freq_d;
			on_time_q       <= on_time_d;
			off_time_q      <= off_time_d;
			cycles_wanted_q <= cycles_wanted_d;
			cycles_done_q   <= cycles_done_d;
			elapsed_q       <= elapsed_d;
			step_index_q    <= step_index_d;
			step_count_q    <= step_count_d;
			table_freq_on_q <= table_freq_on_d;
		end
	end

	// ------------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			tone_on_q    <= sounding_d;
			sound_freq_q <= sounding_d ? driven_freq_d : 16'd0;
			busy_q       <= running_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign tone_on    = tone_on_q;
	assign sound_freq = sound_freq_q;
	assign busy_res   = busy_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_tone_implies_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && tone_on_q |-> busy_q)
		else $error("tone reported without a pattern in progress");

	a_idle_mode_none: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (play_mode_q == MODE_NONE) && !sounding_q)
		else $error("idle block holds a mode or a tone");

	a_template_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		running_q && (play_mode_q == MODE_TEMPLATE) |->
			(step_index_q < step_count_q) && (step_count_q <= DEPTH8))
		else $error("template step outside the table");

	a_repeat_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		running_q && (play_mode_q == MODE_REPEAT) |-> cycles_done_q < cycles_wanted_q)
		else $error("repeat pattern ran past its count");

endmodule : buzzer_pattern_sequencer

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer testbench
// Drives commands and ticks through the valid/stall input channel and checks
// every returned buzzer state against a cycle-free model of the sequencer
// kept inside the bench. Covers single, repeat and template patterns,
// cancellation, table loads while playing, default_freq settings including
// the extremes, random idling on both channels and sustained back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import bps_pkg::*;

	localparam int SLOTS       = TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 12;
	localparam int REPORT_MAX  = 10;
	localparam logic [2:0] CMD_RSVD_A = 3'd6;
	localparam logic [2:0] CMD_RSVD_B = 3'd7;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] dur;
		logic [15:0] pause;
		logic [15:0] freq;
		logic [7:0]  count;
		logic [6:0]  size;
		logic        use_tab;
		logic [5:0]  slot;
		logic [15:0] etime;
		logic [15:0] efreq;
	} beep_req_t;

	typedef struct packed {
		logic        tone;
		logic [15:0] freq;
		logic        busy;
	} buzz_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  command = '0;
	logic [15:0] duration_ms = '0;
	logic [15:0] pause_ms = '0;
	logic [15:0] tone_freq = '0;
	logic [7:0]  repeat_count = '0;
	logic [6:0]  template_size = '0;
	logic        use_freq_table = 1'b0;
	logic [5:0]  entry_index = '0;
	logic [15:0] entry_time = '0;
	logic [15:0] entry_freq = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        tone_on;
	logic [15:0] sound_freq;
	logic        busy_res;

	buzzer_pattern_sequencer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.duration_ms    (duration_ms),
		.pause_ms       (pause_ms),
		.tone_freq      (tone_freq),
		.repeat_count   (repeat_count),
		.template_size  (template_size),
		.use_freq_table (use_freq_table),
		.entry_index    (entry_index),
		.entry_time     (entry_time),
		.entry_freq     (entry_freq),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.tone_on        (tone_on),
		.sound_freq     (sound_freq),
		.busy_res       (busy_res)
	);

	always #10 clk = ~clk;

	// sequencer state as seen from outside
	logic [15:0] dflt_freq = DEFAULT_FREQ_RST;
	mode_t       m_mode = MODE_NONE;
	logic        m_running = 1'b0;
	logic        m_sounding = 1'b0;
	logic [15:0] m_base = '0;
	logic [15:0] m_drive = '0;
	logic [15:0] m_on = '0;
	logic [15:0] m_off = '0;
	logic [7:0]  m_want = '0;
	logic [7:0]  m_done = '0;
	logic [15:0] m_elapsed = '0;
	logic [7:0]  m_step = '0;
	logic [7:0]  m_steps = '0;
	logic        m_use_tab = 1'b0;
	logic [15:0] time_mem [SLOTS];
	logic [15:0] freq_mem [SLOTS];
	bit          slot_loaded [SLOTS];

	buzz_out_t due_outputs [$];
	buzz_out_t head;

	int fault_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int cfg_writes = 0;
	int cycle_count = 0;
	int hold_request = 0;
	int hold_left = 0;
	bit sender_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;

	function automatic void halt_pattern();
		m_sounding = 1'b0;
		m_mode = MODE_NONE;
		m_running = 1'b0;
	endfunction

	function automatic buzz_out_t advance_beeper(input beep_req_t r);
		logic [15:0] chosen;
		int sz;
		buzz_out_t o;
		chosen = (r.freq != 16'd0) ? r.freq : dflt_freq;
		case (r.cmd)
			CMD_TICK: begin
				if (m_running) begin
					if (m_elapsed != 16'hFFFF)
						m_elapsed++;
					case (m_mode)
						MODE_SINGLE: begin
							if (m_elapsed >= m_on)
								halt_pattern();
						end
						MODE_REPEAT: begin
							if (m_sounding && m_elapsed >= m_on) begin
								m_sounding = 1'b0;
								m_elapsed = '0;
							end else if (!m_sounding && m_elapsed >= m_off) begin
								m_done++;
								if (m_done >= m_want) begin
									halt_pattern();
								end else begin
									m_drive = m_base;
									m_sounding = 1'b1;
									m_elapsed = '0;
								end
							end
						end
						MODE_TEMPLATE: begin
							if (m_elapsed >= time_mem[m_step]) begin
								m_elapsed = '0;
								m_step++;
								if (m_step >= m_steps) begin
									halt_pattern();
								end else if (!m_step[0]) begin
									// even steps sound, odd steps are silent
									m_drive = m_use_tab ? freq_mem[m_step >> 1] : m_base;
									m_sounding = 1'b1;
								end else begin
									m_sounding = 1'b0;
								end
							end
						end
						default: halt_pattern();
					endcase
				end
			end
			CMD_SINGLE: begin
				halt_pattern();
				m_mode = MODE_SINGLE;
				m_base = chosen;
				m_on = r.dur;
				m_elapsed = '0;
				m_drive = chosen;
				m_sounding = 1'b1;
				m_running = 1'b1;
			end
			CMD_REPEAT: begin
				halt_pattern();
				if (r.count != 8'd0) begin
					m_mode = MODE_REPEAT;
					m_base = chosen;
					m_on = r.dur;
					m_off = r.pause;
					m_want = r.count;
					m_done = '0;
					m_elapsed = '0;
					m_drive = chosen;
					m_sounding = 1'b1;
					m_running = 1'b1;
				end
			end
			CMD_TEMPLATE: begin
				halt_pattern();
				sz = r.size;
				if (sz > SLOTS)
					sz = SLOTS;
				if (sz != 0) begin
					m_mode = MODE_TEMPLATE;
					m_base = chosen;
					m_use_tab = r.use_tab;
					m_steps = 8'(sz);
					m_step = '0;
					m_elapsed = '0;
					m_drive = r.use_tab ? freq_mem[0] : chosen;
					m_sounding = 1'b1;
					m_running = 1'b1;
				end
			end
			CMD_STOP: halt_pattern();
			CMD_LOAD: begin
				time_mem[r.slot] = r.etime;
				freq_mem[r.slot] = r.efreq;
			end
			default: ;
		endcase
		o.tone = m_sounding;
		o.freq = m_sounding ? m_drive : 16'd0;
		o.busy = m_running;
		return o;
	endfunction

	function automatic beep_req_t noisy_fields();
		beep_req_t r;
		r.cmd     = CMD_TICK;
		r.dur     = 16'($urandom);
		r.pause   = 16'($urandom);
		r.freq    = 16'($urandom);
		r.count   = 8'($urandom);
		r.size    = 7'($urandom);
		r.use_tab = 1'($urandom);
		r.slot    = 6'($urandom);
		r.etime   = 16'($urandom);
		r.efreq   = 16'($urandom);
		return r;
	endfunction

	function automatic int loaded_prefix();
		int n;
		n = 0;
		while (n < SLOTS && slot_loaded[n])
			n++;
		return n;
	endfunction

	task automatic log_fault(input string msg);
		fault_count++;
		if (fault_count <= REPORT_MAX)
			$display("%s", msg);
	endtask

	// sender: one transaction, optionally preceded by an idle gap
	task automatic send_item(input beep_req_t r);
		int gap;
		gap = 0;
		if (sender_idle_on && $urandom_range(99) < IDLE_PCT)
			gap = 1;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (r.cmd == CMD_LOAD)
			slot_loaded[r.slot] = 1'b1;
		in_valid       <= 1'b1;
		command        <= r.cmd;
		duration_ms    <= r.dur;
		pause_ms       <= r.pause;
		tone_freq      <= r.freq;
		repeat_count   <= r.count;
		template_size  <= r.size;
		use_freq_table <= r.use_tab;
		entry_index    <= r.slot;
		entry_time     <= r.etime;
		entry_freq     <= r.efreq;
		do @(posedge clk); while (in_stall);
		due_outputs.push_back(advance_beeper(r));
		items_sent++;
	endtask

	task automatic send_tick();
		beep_req_t r;
		r = noisy_fields();
		r.cmd = CMD_TICK;
		send_item(r);
	endtask

	task automatic send_load(input logic [5:0] slot, input logic [15:0] t,
			input logic [15:0] f);
		beep_req_t r;
		r = noisy_fields();
		r.cmd = CMD_LOAD;
		r.slot = slot;
		r.etime = t;
		r.efreq = f;
		send_item(r);
	endtask

	task automatic send_start(input logic [2:0] cmd, input logic [15:0] freq,
			input logic [15:0] dur, input logic [15:0] pause, input logic [7:0] count,
			input logic [6:0] size, input logic use_tab);
		beep_req_t r;
		r = noisy_fields();
		r.cmd = cmd;
		r.freq = freq;
		r.dur = dur;
		r.pause = pause;
		r.count = count;
		r.size = size;
		r.use_tab = use_tab;
		send_item(r);
	endtask

	// hold input low until every expected result is back
	task automatic settle();
		in_valid <= 1'b0;
		while (due_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_default_freq(input logic [15:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		dflt_freq = v;
		cfg_wr_en <= 1'b0;
		cfg_writes++;
	endtask

	task automatic play_random_pattern();
		beep_req_t r;
		int kind, cap, n, k, span, sel;
		r = noisy_fields();
		kind = $urandom_range(9);
		if (kind <= 2) begin
			r.cmd = CMD_SINGLE;
			if ($urandom_range(15) != 0)
				r.dur = 16'($urandom_range(6));
			if ($urandom_range(7) == 0)
				r.freq = '0;
			send_item(r);
		end else if (kind <= 4) begin
			r.cmd = CMD_REPEAT;
			sel = $urandom_range(15);
			if (sel == 0)
				r.count = '0;
			else if (sel != 1)
				r.count = 8'($urandom_range(4, 1));
			if ($urandom_range(15) != 0)
				r.dur = 16'($urandom_range(3));
			if ($urandom_range(15) != 0)
				r.pause = 16'($urandom_range(3));
			if ($urandom_range(7) == 0)
				r.freq = '0;
			send_item(r);
		end else if (kind <= 7) begin
			// load a few slots; the first two extend the loaded run from slot 0 upward
			k = $urandom_range(4, 1);
			for (int i = 0; i < k; i++) begin
				span = loaded_prefix();
				send_load((i < 2 && span < SLOTS) ? 6'(span) : 6'($urandom_range(SLOTS - 1)),
					($urandom_range(11) == 0) ? 16'($urandom) : 16'($urandom_range(4)),
					16'($urandom));
			end
			span = loaded_prefix();
			sel = $urandom_range(15);
			r.cmd = CMD_TEMPLATE;
			if (sel == 0)
				r.size = '0;
			else if (sel == 1 && span == SLOTS)
				r.size = 7'($urandom_range(127, SLOTS));
			else if (sel == 2)
				r.size = 7'($urandom_range(span, 1));
			else
				r.size = 7'($urandom_range((span < 8) ? span : 8, 1));
			if ($urandom_range(7) == 0)
				r.freq = '0;
			send_item(r);
		end else begin
			k = $urandom_range(3, 1);
			repeat (k) begin
				r = noisy_fields();
				case ($urandom_range(4))
					0: r.cmd = CMD_TICK;
					1: r.cmd = CMD_STOP;
					2: r.cmd = CMD_RSVD_A;
					3: r.cmd = CMD_RSVD_B;
					default: r.cmd = CMD_LOAD;
				endcase
				send_item(r);
			end
			return;
		end
		cap = ($urandom_range(7) == 0) ? $urandom_range(5) : $urandom_range(80, 20);
		n = 0;
		while (m_running && n < cap) begin
			send_tick();
			n++;
		end
		if ($urandom_range(5) == 0)
			send_start(CMD_STOP, '0, '0, '0, '0, '0, 1'b0);
		if ($urandom_range(3) == 0)
			send_tick();
	endtask

	task automatic run_patterns(input int n_items);
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at)
			play_random_pattern();
	endtask

	task automatic test_directed_cases();
		send_tick();
		// reset default frequency for a tone of duration 2, then one of duration 0
		send_start(CMD_SINGLE, '0, 16'd2, '0, '0, '0, 1'b0);
		send_tick();
		send_tick();
		send_start(CMD_SINGLE, 16'hFFFF, '0, '0, '0, '0, 1'b0);
		send_tick();
		send_start(CMD_REPEAT, 16'h1234, 16'd1, 16'd1, '0, '0, 1'b0);
		send_start(CMD_REPEAT, 16'h1234, 16'd1, 16'd1, 8'd2, '0, 1'b0);
		repeat (4) send_tick();
		send_start(CMD_TEMPLATE, 16'd55, '0, '0, '0, '0, 1'b1);
		send_load(6'd0, 16'd1, 16'd500);
		send_load(6'd1, 16'd0, 16'hFFFF);
		send_load(6'd2, 16'd2, 16'd777);
		send_load(6'd63, 16'hFFFF, 16'hFFFF);
		send_start(CMD_TEMPLATE, 16'd55, '0, '0, '0, 7'd3, 1'b1);
		send_tick();
		// reload a slot the running template has still to use
		send_load(6'd2, 16'd1, 16'd4242);
		send_tick();
		send_tick();
		send_start(CMD_SINGLE, 16'd300, 16'd5, '0, '0, '0, 1'b0);
		send_start(CMD_STOP, '0, '0, '0, '0, '0, 1'b0);
		send_start(CMD_RSVD_A, '0, '0, '0, '0, '0, 1'b0);
		send_start(CMD_RSVD_B, '0, '0, '0, '0, '0, 1'b0);
	endtask

	task automatic test_default_freq();
		logic [15:0] settings [4];
		settings = '{16'h0000, 16'hFFFF, 16'($urandom), DEFAULT_FREQ_RST};
		foreach (settings[i]) begin
			set_default_freq(settings[i]);
			send_start(CMD_SINGLE, '0, 16'd1, '0, '0, '0, 1'b0);
			send_tick();
			send_start(CMD_REPEAT, '0, '0, '0, 8'd1, '0, 1'b0);
			send_tick();
			send_tick();
			send_start(CMD_TEMPLATE, '0, '0, '0, '0, 7'd1, 1'b0);
			send_tick();
		end
	endtask

	task automatic test_output_holdoff();
		settle();
		sender_idle_on = 1'b0;
		hold_request = 80;
		run_patterns(40);
		sender_idle_on = 1'b1;
		settle();
	endtask

	task automatic test_full_rate();
		sender_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		run_patterns(300);
		sender_idle_on = 1'b1;
		recv_idle_on = 1'b1;
	endtask

	task automatic test_random_patterns();
		repeat (3) begin
			set_default_freq(16'($urandom));
			run_patterns(530);
		end
	endtask

	// receiver: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= recv_idle_on && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_outputs.size() == 0) begin
				log_fault($sformatf("unexpected result: tone_on=%0b sound_freq=%0d busy_res=%0b",
					tone_on, sound_freq, busy_res));
			end else begin
				head = due_outputs.pop_front();
				results_checked++;
				if (tone_on !== head.tone || sound_freq !== head.freq
						|| busy_res !== head.busy)
					log_fault($sformatf({"mismatch at result %0d: expected tone_on=%0b ",
						"sound_freq=%0d busy_res=%0b, got tone_on=%0b sound_freq=%0d ",
						"busy_res=%0b"}, results_checked, head.tone, head.freq, head.busy,
						tone_on, sound_freq, busy_res));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				due_outputs.size());
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		int waited;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_default_freq();
		test_output_holdoff();
		test_full_rate();
		test_random_patterns();
		in_valid <= 1'b0;
		waited = 0;
		while (due_outputs.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (due_outputs.size() != 0)
			log_fault($sformatf("%0d expected results never arrived", due_outputs.size()));
		$display("summary: %0d transactions sent, %0d results checked, %0d default_freq writes",
			items_sent, results_checked, cfg_writes);
		$display("summary: single/repeat/template patterns, %0d table slots loaded, %0d faults",
			loaded_prefix(), fault_count);
		if (fault_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

`default_nettype wire
